FILE: sv/note_release_follower_core_macros.svh
// ----------------------------------------------------------------------------
// Note release follower - assertion macros
// Same-cycle and next-cycle implication checks on the core clock.
// ----------------------------------------------------------------------------
`ifndef NOTE_RELEASE_FOLLOWER_CORE_MACROS_SVH
`define NOTE_RELEASE_FOLLOWER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define NRF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrf assertion failed");
`define NRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrf assertion failed");
`else
`define NRF_ASSERT_SAME(lbl, ante, cons)
`define NRF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: sv/nrf_pkg.sv
// ----------------------------------------------------------------------------
// Note release follower - package
// Operation codes, sequencer states, shared unit types, register map and reset values.
// ----------------------------------------------------------------------------
package nrf_pkg;

  typedef enum logic [1:0] {
    OP_KEY_ON  = 2'd0,
    OP_KEY_OFF = 2'd1,
    OP_WAIT    = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_GRACE,
    ST_STEP,
    ST_ELAP,
    ST_JUDGE,
    ST_BELOW,
    ST_GATE,
    ST_HOLD,
    ST_RESP
  } state_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD_SAT
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_ctl_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        carry;
  } alu_res_t;

  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_END_ATT     = 3'd1;
  localparam logic [2:0] REG_MIN_GATE    = 3'd2;
  localparam logic [2:0] REG_END_HOLD    = 3'd3;
  localparam logic [2:0] REG_START_GRACE = 3'd4;
  localparam logic [2:0] REG_LEVEL_MUTE  = 3'd5;

  localparam logic        RST_ENABLE      = 1'b1;
  localparam logic [10:0] RST_END_ATT     = 11'd853;
  localparam logic [15:0] RST_MIN_GATE    = 16'd1024;
  localparam logic [15:0] RST_END_HOLD    = 16'd1024;
  localparam logic [15:0] RST_START_GRACE = 16'd256;
  localparam logic        RST_LEVEL_MUTE  = 1'b0;

endpackage

FILE: sv/nrf_alu.sv
// ----------------------------------------------------------------------------
// Note release follower - shared arithmetic unit
// 32-bit subtract with no-borrow flag, or saturating add.
// ----------------------------------------------------------------------------
module nrf_alu
  import nrf_pkg::*;
(
  input  alu_ctl_t ctl,
  output alu_res_t res
);

  logic [32:0] sum;

  always_comb begin
    unique case (ctl.op)
      ALU_SUB:     sum = {1'b0, ctl.a} + {1'b0, ~ctl.b} + 33'd1;
      ALU_ADD_SAT: sum = {1'b0, ctl.a} + {1'b0, ctl.b};
      default:     sum = '0;
    endcase
    res.carry = sum[32];
    if (ctl.op == ALU_ADD_SAT && sum[32]) begin
      res.sum = '1;
    end else begin
      res.sum = sum[31:0];
    end
  end

endmodule

FILE: sv/note_release_follower_core.sv
// ----------------------------------------------------------------------------
// Note release follower - top level
// Per-channel note duration tracking with key-off recommendation.
//
//   port group | direction | handshake
//   in_*       | input     | in_valid / in_ready
//   out_*      | output    | out_valid / out_ready
//   APB        | config    | psel / penable / pwrite, pready tied high
//
// Key-on, key-off, query: load, then response. Wait may add grace, step,
// elapsed, judge, below, gate, hold; sums and bound checks share one unit.
// The next transaction is taken once the result sits in the output register.
// Result stalls hold the sequencer in its response state.
// Reset is synchronous; all channel state clears at once.
// ----------------------------------------------------------------------------
`include "note_release_follower_core_macros.svh"

module note_release_follower_core
  import nrf_pkg::*;
#(
  parameter int CHANNELS = 9
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_channel,
  input  logic [15:0]        in_wait_samples,
  input  logic signed [10:0] in_carrier_attenuation,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_recommend_key_off,
  output logic               out_recommend_mute,
  output logic               out_finished,
  output logic               out_saw_key_off,
  output logic [31:0]        out_elapsed_samples,
  output logic [31:0]        out_below_samples,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int         CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CH_LIM = 5'(CHANNELS);

  // configuration
  logic        enable_r;
  logic [10:0] end_att_r;
  logic [15:0] min_gate_r;
  logic [15:0] end_hold_r;
  logic [15:0] start_grace_r;
  logic        level_mute_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= RST_ENABLE;
      end_att_r     <= RST_END_ATT;
      min_gate_r    <= RST_MIN_GATE;
      end_hold_r    <= RST_END_HOLD;
      start_grace_r <= RST_START_GRACE;
      level_mute_r  <= RST_LEVEL_MUTE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENABLE:      enable_r      <= pwdata[0];
        REG_END_ATT:     end_att_r     <= pwdata[10:0];
        REG_MIN_GATE:    min_gate_r    <= pwdata[15:0];
        REG_END_HOLD:    end_hold_r    <= pwdata[15:0];
        REG_START_GRACE: start_grace_r <= pwdata[15:0];
        REG_LEVEL_MUTE:  level_mute_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:      prdata = {31'd0, enable_r};
      REG_END_ATT:     prdata = {21'd0, end_att_r};
      REG_MIN_GATE:    prdata = {16'd0, min_gate_r};
      REG_END_HOLD:    prdata = {16'd0, end_hold_r};
      REG_START_GRACE: prdata = {16'd0, start_grace_r};
      REG_LEVEL_MUTE:  prdata = {31'd0, level_mute_r};
      default:         prdata = '0;
    endcase
  end

  // channel state
  logic        act_r   [CHANNELS];
  logic        seen_r  [CHANNELS];
  logic        rel_r   [CHANNELS];
  logic [15:0] grace_r [CHANNELS];
  logic [31:0] since_r [CHANNELS];
  logic [31:0] below_r [CHANNELS];

  // sequencer and working registers
  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [3:0]         ch_r;
  logic [15:0]        wait_r;
  logic signed [10:0] att_r;
  logic               in_range_r, in_range_nxt;
  logic               w_act_r, w_act_nxt;
  logic               w_seen_r, w_seen_nxt;
  logic               w_rel_r, w_rel_nxt;
  logic [15:0]        w_grace_r, w_grace_nxt;
  logic [31:0]        w_since_r, w_since_nxt;
  logic [31:0]        w_below_r, w_below_nxt;
  logic [15:0]        step_r, step_nxt;
  logic               judge_r, judge_nxt;
  logic               is_below_r, is_below_nxt;
  logic               gate_ok_r, gate_ok_nxt;
  logic               rec_r, rec_nxt;
  logic               out_valid_r;
  logic               out_rec_r, out_mute_r, out_fin_r, out_seen_r;
  logic [31:0]        out_since_r, out_below_r;

  logic [CH_W-1:0] idx;
  logic            in_acc;
  logic            out_free;
  logic            resp_fire;
  alu_ctl_t        alu_ctl;
  alu_res_t        alu_res;

  assign idx       = ch_r[CH_W-1:0];
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign resp_fire = (state_r == ST_RESP) && out_free;

  nrf_alu u_alu (
    .ctl (alu_ctl),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_range_nxt = in_range_r;
    w_act_nxt    = w_act_r;
    w_seen_nxt   = w_seen_r;
    w_rel_nxt    = w_rel_r;
    w_grace_nxt  = w_grace_r;
    w_since_nxt  = w_since_r;
    w_below_nxt  = w_below_r;
    step_nxt     = step_r;
    judge_nxt    = judge_r;
    is_below_nxt = is_below_r;
    gate_ok_nxt  = gate_ok_r;
    rec_nxt      = rec_r;
    alu_ctl.op   = ALU_SUB;
    alu_ctl.a    = '0;
    alu_ctl.b    = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_range_nxt = ({1'b0, in_channel} < CH_LIM);
        if (in_acc) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rec_nxt   = 1'b0;
        judge_nxt = 1'b1;
        state_nxt = ST_RESP;
        if (!in_range_r) begin
          w_act_nxt   = 1'b0;
          w_seen_nxt  = 1'b0;
          w_rel_nxt   = 1'b0;
          w_grace_nxt = '0;
          w_since_nxt = '0;
          w_below_nxt = '0;
        end else begin
          w_act_nxt   = act_r[idx];
          w_seen_nxt  = seen_r[idx];
          w_rel_nxt   = rel_r[idx];
          w_grace_nxt = grace_r[idx];
          w_since_nxt = since_r[idx];
          w_below_nxt = below_r[idx];
          unique case (op_r)
            OP_KEY_ON: begin
              w_act_nxt   = 1'b1;
              w_seen_nxt  = 1'b0;
              w_rel_nxt   = 1'b0;
              w_grace_nxt = start_grace_r;
              w_since_nxt = '0;
              w_below_nxt = '0;
            end
            OP_KEY_OFF: begin
              w_seen_nxt = seen_r[idx] | act_r[idx];
            end
            OP_WAIT: begin
              if (enable_r && act_r[idx] && (wait_r != '0)) begin
                state_nxt = ST_GRACE;
              end
            end
            OP_QUERY: ;
            default: ;
          endcase
        end
      end
      ST_GRACE: begin
        alu_ctl.op = ALU_SUB;
        alu_ctl.a  = {16'd0, w_grace_r};
        alu_ctl.b  = {16'd0, wait_r};
        if (w_grace_r == '0) begin
          step_nxt  = wait_r;
          state_nxt = ST_ELAP;
        end else if (alu_res.carry) begin
          // grace covers the whole wait
          w_grace_nxt = alu_res.sum[15:0];
          judge_nxt   = 1'b0;
          state_nxt   = ST_ELAP;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        alu_ctl.op  = ALU_SUB;
        alu_ctl.a   = {16'd0, wait_r};
        alu_ctl.b   = {16'd0, w_grace_r};
        step_nxt    = alu_res.sum[15:0];
        w_grace_nxt = '0;
        state_nxt   = ST_ELAP;
      end
      ST_ELAP: begin
        // grace and judged part together advance the elapsed count by the wait
        alu_ctl.op  = ALU_ADD_SAT;
        alu_ctl.a   = w_since_r;
        alu_ctl.b   = {16'd0, wait_r};
        w_since_nxt = alu_res.sum;
        state_nxt   = judge_r ? ST_JUDGE : ST_RESP;
      end
      ST_JUDGE: begin
        alu_ctl.op   = ALU_SUB;
        alu_ctl.a    = {22'd0, att_r[9:0]};
        alu_ctl.b    = {21'd0, end_att_r};
        is_below_nxt = att_r[10] || alu_res.carry;
        state_nxt    = ST_BELOW;
      end
      ST_BELOW: begin
        alu_ctl.op  = ALU_ADD_SAT;
        alu_ctl.a   = w_below_r;
        alu_ctl.b   = {16'd0, step_r};
        w_below_nxt = is_below_r ? alu_res.sum : '0;
        state_nxt   = ST_GATE;
      end
      ST_GATE: begin
        alu_ctl.op  = ALU_SUB;
        alu_ctl.a   = w_since_r;
        alu_ctl.b   = {16'd0, min_gate_r};
        gate_ok_nxt = alu_res.carry;
        state_nxt   = ST_HOLD;
      end
      ST_HOLD: begin
        alu_ctl.op = ALU_SUB;
        alu_ctl.a  = w_below_r;
        alu_ctl.b  = {16'd0, end_hold_r};
        if (!w_rel_r && gate_ok_r && alu_res.carry) begin
          w_rel_nxt = 1'b1;
          rec_nxt   = 1'b1;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= op_t'(in_operation);
      ch_r   <= in_channel;
      wait_r <= in_wait_samples;
      att_r  <= in_carrier_attenuation;
    end
    in_range_r <= in_range_nxt;
    w_act_r    <= w_act_nxt;
    w_seen_r   <= w_seen_nxt;
    w_rel_r    <= w_rel_nxt;
    w_grace_r  <= w_grace_nxt;
    w_since_r  <= w_since_nxt;
    w_below_r  <= w_below_nxt;
    step_r     <= step_nxt;
    judge_r    <= judge_nxt;
    is_below_r <= is_below_nxt;
    gate_ok_r  <= gate_ok_nxt;
    rec_r      <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        act_r[i]   <= 1'b0;
        seen_r[i]  <= 1'b0;
        rel_r[i]   <= 1'b0;
        grace_r[i] <= '0;
        since_r[i] <= '0;
        below_r[i] <= '0;
      end
    end else if (resp_fire && in_range_r) begin
      act_r[idx]   <= w_act_r;
      seen_r[idx]  <= w_seen_r;
      rel_r[idx]   <= w_rel_r;
      grace_r[idx] <= w_grace_r;
      since_r[idx] <= w_since_r;
      below_r[idx] <= w_below_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_fire) begin
      out_rec_r   <= rec_r;
      out_mute_r  <= rec_r & level_mute_r;
      out_fin_r   <= !w_act_r;
      out_seen_r  <= w_seen_r;
      out_since_r <= w_since_r;
      out_below_r <= w_below_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_recommend_key_off = out_rec_r;
  assign out_recommend_mute    = out_mute_r;
  assign out_finished          = out_fin_r;
  assign out_saw_key_off       = out_seen_r;
  assign out_elapsed_samples   = out_since_r;
  assign out_below_samples     = out_below_r;

  `NRF_ASSERT_SAME(a_mute_needs_rec, out_valid_r && out_mute_r, out_rec_r)
  `NRF_ASSERT_SAME(a_rec_only_active, out_valid_r && out_rec_r, !out_fin_r)
  `NRF_ASSERT_NEXT(a_accept_loads, in_acc, state_r == ST_LOAD)
  `NRF_ASSERT_NEXT(a_out_drains, out_valid_r && out_ready && !resp_fire, !out_valid_r)

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note release follower - testbench
// Directed table then random phased traffic against a behavioural tracker of
// all nine channels; results are scored in order, field by field, under
// varying register settings and varying source and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import nrf_pkg::*;

  localparam int NCH         = 9;
  localparam int PHASE_ITEMS = 190;
  localparam int NUM_PHASES  = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        key_off;
    logic        mute;
    logic        finished;
    logic        saw_off;
    logic [31:0] elapsed;
    logic [31:0] below;
  } release_status_t;

  typedef struct {
    op_t             op;
    logic [3:0]      ch;
    logic [15:0]     ws;
    logic [10:0]     att;
    bit              lit;
    release_status_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_operation;
  logic [3:0]         in_channel;
  logic [15:0]        in_wait_samples;
  logic signed [10:0] in_carrier_attenuation;
  logic               out_valid;
  logic               out_ready;
  logic               out_recommend_key_off;
  logic               out_recommend_mute;
  logic               out_finished;
  logic               out_saw_key_off;
  logic [31:0]        out_elapsed_samples;
  logic [31:0]        out_below_samples;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // literal expectation travelling with the driven transaction
  bit                 drv_lit;
  release_status_t    drv_lit_want;

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;

  release_status_t release_q[$];

  // register shadow
  logic        m_enable;
  logic [10:0] m_end_att;
  logic [15:0] m_gate;
  logic [15:0] m_hold;
  logic [15:0] m_grace;
  logic        m_mute;

  // per-channel tracker
  logic        trk_active   [NCH];
  logic        trk_saw_off  [NCH];
  logic        trk_released [NCH];
  logic [15:0] trk_grace    [NCH];
  logic [31:0] trk_elapsed  [NCH];
  logic [31:0] trk_below    [NCH];

  note_release_follower_core #(
    .CHANNELS(NCH)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_channel            (in_channel),
    .in_wait_samples       (in_wait_samples),
    .in_carrier_attenuation(in_carrier_attenuation),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_recommend_key_off (out_recommend_key_off),
    .out_recommend_mute    (out_recommend_mute),
    .out_finished          (out_finished),
    .out_saw_key_off       (out_saw_key_off),
    .out_elapsed_samples   (out_elapsed_samples),
    .out_below_samples     (out_below_samples),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL note_release_follower_core");
    $finish;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic string fmt_status(release_status_t s);
    return $sformatf("ko=%0b mu=%0b fin=%0b saw=%0b el=%0d bl=%0d",
                     s.key_off, s.mute, s.finished, s.saw_off, s.elapsed, s.below);
  endfunction

  // applies one transaction to the tracker and returns the channel status
  function automatic release_status_t track_release(op_t op, logic [3:0] ch,
                                                    logic [15:0] ws, logic [10:0] att);
    release_status_t r;
    logic [31:0]     step;
    logic            is_below;
    r = '0;
    if (ch >= NCH) begin
      r.finished = 1'b1;
      return r;
    end
    case (op)
      OP_KEY_ON: begin
        trk_active[ch]   = 1'b1;
        trk_saw_off[ch]  = 1'b0;
        trk_released[ch] = 1'b0;
        trk_grace[ch]    = m_grace;
        trk_elapsed[ch]  = '0;
        trk_below[ch]    = '0;
      end
      OP_KEY_OFF: begin
        if (trk_active[ch]) trk_saw_off[ch] = 1'b1;
      end
      OP_WAIT: begin
        if (m_enable && trk_active[ch] && ws != 16'd0) begin
          if (trk_grace[ch] >= ws) begin
            // grace swallows the whole wait: no judgement
            trk_grace[ch]   = trk_grace[ch] - ws;
            trk_elapsed[ch] = sat_add32(trk_elapsed[ch], 32'(ws));
          end else begin
            step            = 32'(ws) - 32'(trk_grace[ch]);
            trk_elapsed[ch] = sat_add32(trk_elapsed[ch], 32'(trk_grace[ch]));
            trk_grace[ch]   = '0;
            is_below        = att[10] || ({1'b0, att[9:0]} >= m_end_att);
            trk_below[ch]   = is_below ? sat_add32(trk_below[ch], step) : 32'd0;
            trk_elapsed[ch] = sat_add32(trk_elapsed[ch], step);
            if (!trk_released[ch] && trk_elapsed[ch] >= 32'(m_gate) &&
                trk_below[ch] >= 32'(m_hold)) begin
              trk_released[ch] = 1'b1;
              r.key_off        = 1'b1;
              r.mute           = m_mute;
            end
          end
        end
      end
      default: ;
    endcase
    r.finished = ~trk_active[ch];
    r.saw_off  = trk_saw_off[ch];
    r.elapsed  = trk_elapsed[ch];
    r.below    = trk_below[ch];
    return r;
  endfunction

  always @(posedge clk) begin : p_score
    release_status_t got;
    release_status_t want;
    release_status_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.key_off  = out_recommend_key_off;
        got.mute     = out_recommend_mute;
        got.finished = out_finished;
        got.saw_off  = out_saw_key_off;
        got.elapsed  = out_elapsed_samples;
        got.below    = out_below_samples;
        if (release_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result transaction: %s", $realtime, fmt_status(got));
        end else begin
          want = release_q.pop_front();
          if (got.key_off !== want.key_off || got.mute !== want.mute ||
              got.finished !== want.finished || got.saw_off !== want.saw_off ||
              got.elapsed !== want.elapsed || got.below !== want.below) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch\n  exp %s\n  got %s", $realtime,
                       fmt_status(want), fmt_status(got));
          end
        end
      end
      if (in_valid && in_ready) begin
        pred = track_release(op_t'(in_operation), in_channel, in_wait_samples,
                             in_carrier_attenuation);
        release_q.push_back(drv_lit ? drv_lit_want : pred);
      end
    end
  end

  task automatic send_item(op_t op, logic [3:0] ch, logic [15:0] ws, logic [10:0] att,
                           bit lit, release_status_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_operation           <= op;
    in_channel             <= ch;
    in_wait_samples        <= ws;
    in_carrier_attenuation <= att;
    drv_lit                <= lit;
    drv_lit_want           <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_item();
    int          r;
    int          a;
    op_t         op;
    logic [3:0]  ch;
    logic [15:0] ws;
    logic [10:0] att;
    r = $urandom_range(99);
    if (r < 8)       op = OP_KEY_ON;
    else if (r < 16) op = OP_KEY_OFF;
    else if (r < 26) op = OP_QUERY;
    else             op = OP_WAIT;
    ch = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(NCH - 1));
    case ($urandom_range(7))
      0:       ws = '0;
      1, 2:    ws = 16'($urandom());
      default: ws = 16'($urandom_range(2500, 1));
    endcase
    case ($urandom_range(7))
      0:       att = 11'($urandom_range(2047, 1024));
      1, 2:    att = 11'($urandom_range(1023));
      default: begin
        // hover around the threshold
        a = int'(m_end_att) + int'($urandom_range(40)) - 20;
        if (a < 0) a = 0;
        if (a > 1023) a = 1023;
        att = 11'(a);
      end
    endcase
    send_item(op, ch, ws, att, 1'b0, '0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ENABLE:      m_enable  = val[0];
      REG_END_ATT:     m_end_att = val[10:0];
      REG_MIN_GATE:    m_gate    = val[15:0];
      REG_END_HOLD:    m_hold    = val[15:0];
      REG_START_GRACE: m_grace   = val[15:0];
      REG_LEVEL_MUTE:  m_mute    = val[0];
      default: ;
    endcase
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (release_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin : p_main
    dir_row_t    dir_tab [22];
    logic [31:0] v_en, v_att, v_gate, v_hold, v_grace, v_mute;
    rst_n                  = 1'b0;
    in_valid               = 1'b0;
    in_operation           = '0;
    in_channel             = '0;
    in_wait_samples        = '0;
    in_carrier_attenuation = '0;
    out_ready              = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    drv_lit                = 1'b0;
    drv_lit_want           = '0;
    fail_count             = 0;
    send_idle_pct          = 7;
    recv_idle_pct          = 56;
    m_enable               = RST_ENABLE;
    m_end_att              = RST_END_ATT;
    m_gate                 = RST_MIN_GATE;
    m_hold                 = RST_END_HOLD;
    m_grace                = RST_START_GRACE;
    m_mute                 = RST_LEVEL_MUTE;
    for (int c = 0; c < NCH; c++) begin
      trk_active[c]   = 1'b0;
      trk_saw_off[c]  = 1'b0;
      trk_released[c] = 1'b0;
      trk_grace[c]    = '0;
      trk_elapsed[c]  = '0;
      trk_below[c]    = '0;
    end

    // reset register values: grace 256, threshold 853, gate 1024, hold 1024
    dir_tab = '{
      '{OP_QUERY,   4'd0,  16'd0,     11'd0,     1'b1, '{0, 0, 1, 0, 0,     0}},
      '{OP_KEY_OFF, 4'd0,  16'd0,     11'd0,     1'b1, '{0, 0, 1, 0, 0,     0}},
      '{OP_WAIT,    4'd0,  16'd100,   11'd1023,  1'b1, '{0, 0, 1, 0, 0,     0}},
      '{OP_KEY_ON,  4'd15, 16'hFFFF,  11'h7FF,   1'b1, '{0, 0, 1, 0, 0,     0}},
      '{OP_WAIT,    4'd9,  16'hFFFF,  11'h400,   1'b1, '{0, 0, 1, 0, 0,     0}},
      '{OP_KEY_ON,  4'd0,  16'd0,     11'd0,     1'b1, '{0, 0, 0, 0, 0,     0}},
      '{OP_WAIT,    4'd0,  16'd0,     11'd1023,  1'b1, '{0, 0, 0, 0, 0,     0}},
      '{OP_WAIT,    4'd0,  16'd200,   11'd1023,  1'b1, '{0, 0, 0, 0, 200,   0}},
      '{OP_WAIT,    4'd0,  16'd56,    11'd1023,  1'b1, '{0, 0, 0, 0, 256,   0}},
      '{OP_WAIT,    4'd0,  16'd1000,  11'd853,   1'b1, '{0, 0, 0, 0, 1256,  1000}},
      '{OP_WAIT,    4'd0,  16'd24,    11'h7FF,   1'b1, '{1, 0, 0, 0, 1280,  1024}},
      '{OP_WAIT,    4'd0,  16'd500,   11'd1023,  1'b1, '{0, 0, 0, 0, 1780,  1524}},
      '{OP_WAIT,    4'd0,  16'd10,    11'd852,   1'b1, '{0, 0, 0, 0, 1790,  0}},
      '{OP_KEY_OFF, 4'd0,  16'd0,     11'd0,     1'b1, '{0, 0, 0, 1, 1790,  0}},
      '{OP_QUERY,   4'd0,  16'hFFFF,  11'h400,   1'b1, '{0, 0, 0, 1, 1790,  0}},
      '{OP_KEY_ON,  4'd8,  16'd0,     11'd0,     1'b1, '{0, 0, 0, 0, 0,     0}},
      '{OP_WAIT,    4'd8,  16'hFFFF,  11'h400,   1'b1, '{1, 0, 0, 0, 65535, 65279}},
      '{OP_KEY_OFF, 4'd8,  16'd0,     11'd0,     1'b1, '{0, 0, 0, 1, 65535, 65279}},
      '{OP_KEY_ON,  4'd8,  16'd0,     11'd0,     1'b1, '{0, 0, 0, 0, 0,     0}},
      '{OP_WAIT,    4'd0,  16'd1,     11'd1023,  1'b1, '{0, 0, 0, 1, 1791,  1}},
      '{OP_QUERY,   4'd7,  16'h5A5A,  11'h2AA,   1'b0, '{0, 0, 0, 0, 0,     0}},
      '{OP_WAIT,    4'd8,  16'd300,   11'd900,   1'b0, '{0, 0, 0, 0, 0,     0}}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].ws, dir_tab[i].att,
                dir_tab[i].lit, dir_tab[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        settle_idle();
        case (p)
          1: begin
            v_en = 1; v_att = 0; v_gate = 0; v_hold = 0; v_grace = 0; v_mute = 1;
          end
          2: begin
            v_en = 0; v_att = $urandom_range(1024); v_gate = $urandom_range(4000);
            v_hold = $urandom_range(4000); v_grace = $urandom_range(500);
            v_mute = $urandom_range(1);
          end
          3: begin
            v_en = 1; v_att = 1024; v_gate = 65535; v_hold = 65535; v_grace = 65535;
            v_mute = 1;
          end
          4: begin
            v_en = 1; v_att = 853; v_gate = 1; v_hold = 1; v_grace = 1; v_mute = 0;
          end
          default: begin
            v_en    = ($urandom_range(7) != 0);
            v_att   = $urandom_range(1024);
            v_gate  = ($urandom_range(3) == 0) ? 32'($urandom_range(65535))
                                               : 32'($urandom_range(8000));
            v_hold  = ($urandom_range(3) == 0) ? 32'($urandom_range(65535))
                                               : 32'($urandom_range(8000));
            v_grace = $urandom_range(1000);
            v_mute  = $urandom_range(1);
          end
        endcase
        write_reg(REG_ENABLE,      v_en);
        write_reg(REG_END_ATT,     v_att);
        write_reg(REG_MIN_GATE,    v_gate);
        write_reg(REG_END_HOLD,    v_hold);
        write_reg(REG_START_GRACE, v_grace);
        write_reg(REG_LEVEL_MUTE,  v_mute);
      end
      if (p < 3) begin
        send_idle_pct = 7;
        recv_idle_pct = 56;
      end else if (p < 7) begin
        send_idle_pct = 56;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (PHASE_ITEMS) random_item();
    end

    settle_idle();
    if (fail_count == 0 && release_q.size() == 0)
      $display("PASS note_release_follower_core");
    else
      $display("FAIL note_release_follower_core");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/nrf_pkg.sv
sv/nrf_alu.sv
sv/note_release_follower_core.sv
verif/tb_top.sv
